/* rtl/core/link_frame_receive_checker_macros.svh */
// Assertion macros shared by the link frame receive checker RTL.
`ifndef LINK_FRAME_RECEIVE_CHECKER_MACROS_SVH
`define LINK_FRAME_RECEIVE_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lfrc_pkg.sv */
// Package with types, codes and defaults for the link frame receive checker.
package lfrc_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 256;

    localparam logic [7:0] TIMEOUT_RESET = 8'd20;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int VERDICT_W = 4;
    localparam int COUNT_W  = 14;

    localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

    localparam logic [VERDICT_W-1:0] V_ACK     = 4'd0;
    localparam logic [VERDICT_W-1:0] V_DATA    = 4'd1;
    localparam logic [VERDICT_W-1:0] V_BADHDR  = 4'd2;
    localparam logic [VERDICT_W-1:0] V_BADKIND = 4'd3;
    localparam logic [VERDICT_W-1:0] V_CSUM    = 4'd4;
    localparam logic [VERDICT_W-1:0] V_NONE    = 4'd5;
    localparam logic [VERDICT_W-1:0] V_ERR9    = 4'd14;
    localparam logic [VERDICT_W-1:0] V_LAST    = 4'd14;

    localparam logic [7:0] HEADER_BYTE = 8'hAB;
    localparam logic [7:0] ACK_BYTE    = 8'h55;
    localparam logic [7:0] ERR_FIRST   = 8'h41;
    localparam logic [7:0] ERR_LAST    = 8'h48;
    localparam logic [7:0] ERR_NINE    = 8'h5F;

    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_STATUS = 3'd2;

    localparam logic [COUNT_W-1:0] LEN_LOW_INDEX = 14'd2;
    localparam logic [COUNT_W-1:0] LEN_OVERHEAD  = 14'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_HEAD = 3'd1,
        ST_KIND = 3'd2,
        ST_LEN  = 3'd3,
        ST_BODY = 3'd4,
        ST_WAIT = 3'd5
    } stage_t;

endpackage

/* rtl/core/link_frame_receive_checker.sv */
// Link frame receive checker: parses one frame per start transaction and reports a verdict.
//
//  Port group        Dir  Contents
//  s_t*              in   transaction: opcode, rx_byte
//  m_t*              out  result transaction: verdict, frame_bytes
//  timeout_ticks_*   in   write of the timeout register
//
// One transaction is taken per cycle while s_tready is high; it is held in the input register and
// processed against the frame state into the result register. A transaction that ends a frame has its
// verdict offered on m_t* after it has passed through the input register and then the result register.
// The single output register sets the stall behavior: s_tready drops only while the input
// register is full, a result is held and m_tready is low.
// Reset clears the frame state to idle and loads the timeout register with 20.
module link_frame_receive_checker #(
    parameter int BUFFER_BYTES = lfrc_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,              // [1:0] opcode, [9:2] rx_byte, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,              // [3:0] verdict, [17:4] frame_bytes, rest zero
    input  logic        timeout_ticks_we,
    input  logic [7:0]  timeout_ticks_wdata
);
    import lfrc_pkg::*;

    `include "link_frame_receive_checker_macros.svh"

    localparam logic [COUNT_W-1:0] BUF_LIMIT = COUNT_W'(BUFFER_BYTES);

    logic [7:0]          timeout_reg;

    logic                in_valid_reg;
    logic [OPCODE_W-1:0] in_opcode_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    stage_t              stage_reg, stage_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [7:0]          len_low_reg, len_low_next;
    logic [COUNT_W-1:0]  exp_len_reg, exp_len_next;
    logic [7:0]          xor_reg, xor_next;
    logic [7:0]          ticks_reg, ticks_next;

    logic                out_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [COUNT_W-1:0]  frame_bytes_reg, frame_bytes_next;

    logic                advance;
    logic                fire;
    logic                emit;
    logic [COUNT_W-1:0]  count_inc;
    logic [16:0]         len_bits;
    logic [COUNT_W-1:0]  exp_calc;
    logic [7:0]          ticks_dec;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, frame_bytes_reg, verdict_reg};

    assign count_inc = count_reg + 14'd1;
    assign len_bits  = {1'b0, in_byte_reg, len_low_reg} + 17'd7;
    assign exp_calc  = len_bits[16:3] + LEN_OVERHEAD;
    assign ticks_dec = (ticks_reg != 8'd0) ? ticks_reg - 8'd1 : 8'd0;

    always_comb
    begin
        stage_next       = stage_reg;
        count_next       = count_reg;
        len_low_next     = len_low_reg;
        exp_len_next     = exp_len_reg;
        xor_next         = xor_reg;
        ticks_next       = ticks_reg;
        emit             = 1'b0;
        verdict_next     = V_NONE;
        frame_bytes_next = count_reg;

        if (fire)
        begin
            case (in_opcode_reg)
                OP_START:
                begin
                    stage_next   = ST_HEAD;
                    count_next   = '0;
                    len_low_next = '0;
                    exp_len_next = '0;
                    xor_next     = '0;
                    ticks_next   = timeout_reg;
                end
                OP_BYTE:
                begin
                    if (stage_reg != ST_IDLE)
                    begin
                        count_next       = count_inc;
                        frame_bytes_next = count_inc;
                        case (stage_reg)
                            ST_HEAD:
                            begin
                                if (in_byte_reg != HEADER_BYTE)
                                begin
                                    emit         = 1'b1;
                                    verdict_next = V_BADHDR;
                                end
                                else
                                begin
                                    stage_next = ST_KIND;
                                end
                            end
                            ST_KIND:
                            begin
                                if (in_byte_reg[7:5] == KIND_STATUS)
                                begin
                                    if (in_byte_reg == ACK_BYTE)
                                    begin
                                        emit         = 1'b1;
                                        verdict_next = V_ACK;
                                    end
                                    else if (in_byte_reg inside {[ERR_FIRST:ERR_LAST]})
                                    begin
                                        emit         = 1'b1;
                                        verdict_next = in_byte_reg[3:0] + 4'd5;
                                    end
                                    else if (in_byte_reg == ERR_NINE)
                                    begin
                                        emit         = 1'b1;
                                        verdict_next = V_ERR9;
                                    end
                                    else
                                    begin
                                        stage_next = ST_WAIT;
                                    end
                                end
                                else if (in_byte_reg[7:5] == KIND_DATA)
                                begin
                                    xor_next   = in_byte_reg;
                                    stage_next = ST_LEN;
                                end
                                else
                                begin
                                    emit         = 1'b1;
                                    verdict_next = V_BADKIND;
                                end
                            end
                            ST_LEN:
                            begin
                                xor_next = xor_reg ^ in_byte_reg;
                                if (count_reg == LEN_LOW_INDEX)
                                begin
                                    len_low_next = in_byte_reg;
                                end
                                else
                                begin
                                    exp_len_next = exp_calc;
                                    stage_next   = ST_BODY;
                                end
                            end
                            ST_BODY:
                            begin
                                if ({1'b0, count_reg} + 15'd1 == {1'b0, exp_len_reg})
                                begin
                                    emit             = 1'b1;
                                    verdict_next     = (xor_reg == in_byte_reg) ? V_DATA : V_CSUM;
                                    frame_bytes_next = exp_len_reg;
                                end
                                else
                                begin
                                    xor_next = xor_reg ^ in_byte_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase

                        if (!emit && (count_next >= BUF_LIMIT))
                        begin
                            emit             = 1'b1;
                            verdict_next     = V_NONE;
                            frame_bytes_next = (stage_next == ST_BODY) ? exp_len_next : count_next;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (stage_reg != ST_IDLE)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == 8'd0)
                        begin
                            emit             = 1'b1;
                            verdict_next     = V_NONE;
                            frame_bytes_next = (stage_reg == ST_BODY) ? exp_len_reg : count_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (emit)
            begin
                stage_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (timeout_ticks_we)
        begin
            timeout_reg <= timeout_ticks_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_opcode_reg <= s_tdata[1:0];
            in_byte_reg   <= s_tdata[9:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_IDLE;
            count_reg   <= '0;
            len_low_reg <= '0;
            exp_len_reg <= '0;
            xor_reg     <= '0;
            ticks_reg   <= '0;
        end
        else
        begin
            stage_reg   <= stage_next;
            count_reg   <= count_next;
            len_low_reg <= len_low_next;
            exp_len_reg <= exp_len_next;
            xor_reg     <= xor_next;
            ticks_reg   <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            verdict_reg     <= verdict_next;
            frame_bytes_reg <= frame_bytes_next;
        end
    end

    `LFRC_ASSERT_NEXT(a_idle_after_result, fire && emit, stage_reg == ST_IDLE, "Frame still open after a result.")
    `LFRC_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, s_tready, "Input stalled with an empty output register.")
    `LFRC_ASSERT_SAME(a_verdict_range, out_valid_reg, verdict_reg <= V_LAST, "Verdict code out of range.")
    `LFRC_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= BUF_LIMIT, "Byte count passed the buffer size.")

endmodule

/* verif/tb_link_frame_receive_checker.sv */
// Self-checking testbench for the link frame receive checker with a built-in frame predictor.
module tb_link_frame_receive_checker;
    import lfrc_pkg::*;

    localparam logic [OPCODE_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [VERDICT_W-1:0] V_ERR1    = V_ERR9 - 4'd8;
    localparam int                   SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   frame_bytes;
    } frame_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        timeout_ticks_we = 1'b0;
    logic [7:0]  timeout_ticks_wdata = '0;

    // Predicted frame state.
    logic [7:0]         pred_timeout;
    stage_t             pred_stage;
    logic [COUNT_W-1:0] pred_count;
    logic [7:0]         pred_len_low;
    logic [COUNT_W-1:0] pred_frame_len;
    logic [7:0]         pred_xor;
    logic [7:0]         pred_ticks;

    frame_verdict_t verdict_q[$];
    frame_verdict_t oldest;
    int  mismatches = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    logic [15:0] verdicts_seen = '0;

    link_frame_receive_checker dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .timeout_ticks_we    (timeout_ticks_we),
        .timeout_ticks_wdata (timeout_ticks_wdata)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic push_verdict(input logic [VERDICT_W-1:0] v, input logic [COUNT_W-1:0] n);
        frame_verdict_t fv;
        fv.verdict = v;
        fv.frame_bytes = n;
        verdict_q.push_back(fv);
        pred_stage = ST_IDLE;
    endtask

    function automatic logic [COUNT_W-1:0] reported_length();
        return (pred_stage == ST_BODY) ? pred_frame_len : pred_count;
    endfunction

    task automatic predict_frame_step(input logic [OPCODE_W-1:0] op, input logic [7:0] b);
        logic [COUNT_W-1:0] idx;
        logic [16:0]        bits;
        logic [2:0]         kind;
        if (op == OP_START)
        begin
            pred_stage = ST_HEAD;
            pred_count = '0;
            pred_len_low = '0;
            pred_frame_len = '0;
            pred_xor = '0;
            pred_ticks = pred_timeout;
            return;
        end
        if (pred_stage == ST_IDLE || op == OP_UNUSED)
        begin
            return;
        end
        if (op == OP_TICK)
        begin
            if (pred_ticks != 0)
            begin
                pred_ticks = pred_ticks - 8'd1;
            end
            if (pred_ticks == 0)
            begin
                push_verdict(V_NONE, reported_length());
            end
            return;
        end
        idx = pred_count;
        pred_count = pred_count + 14'd1;
        kind = b[7:5];
        case (pred_stage)
            ST_HEAD:
            begin
                if (b != HEADER_BYTE)
                begin
                    push_verdict(V_BADHDR, pred_count);
                end
                else
                begin
                    pred_stage = ST_KIND;
                end
            end
            ST_KIND:
            begin
                if (kind == KIND_STATUS)
                begin
                    if (b == ACK_BYTE)
                    begin
                        push_verdict(V_ACK, pred_count);
                    end
                    else if (b >= ERR_FIRST && b <= ERR_LAST)
                    begin
                        push_verdict(V_ERR1 + 4'(b - ERR_FIRST), pred_count);
                    end
                    else if (b == ERR_NINE)
                    begin
                        push_verdict(V_ERR9, pred_count);
                    end
                    else
                    begin
                        pred_stage = ST_WAIT;
                    end
                end
                else if (kind == KIND_DATA)
                begin
                    pred_xor = b;
                    pred_stage = ST_LEN;
                end
                else
                begin
                    push_verdict(V_BADKIND, pred_count);
                end
            end
            ST_LEN:
            begin
                pred_xor = pred_xor ^ b;
                if (idx == LEN_LOW_INDEX)
                begin
                    pred_len_low = b;
                end
                else
                begin
                    bits = {1'b0, b, pred_len_low};
                    pred_frame_len = COUNT_W'(((bits + 17'd7) >> 3) + 17'(LEN_OVERHEAD));
                    pred_stage = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (idx + 14'd1 == pred_frame_len)
                begin
                    push_verdict((pred_xor == b) ? V_DATA : V_CSUM, pred_frame_len);
                end
                else
                begin
                    pred_xor = pred_xor ^ b;
                end
            end
            default:
            begin
            end
        endcase
        if (pred_stage != ST_IDLE && pred_count >= COUNT_W'(BUFFER_BYTES_DEFAULT))
        begin
            push_verdict(V_NONE, reported_length());
        end
    endtask

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, b, op};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        predict_frame_step(op, b);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (verdict_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived", verdict_q.size()));
            verdict_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] ticks);
        wait_drained();
        timeout_ticks_we <= 1'b1;
        timeout_ticks_wdata <= ticks;
        @(posedge clk);
        pred_timeout = ticks;
        timeout_ticks_we <= 1'b0;
    endtask

    task automatic send_data_frame(input logic [15:0] bits, input bit corrupt, input int tick_pct,
                                   input int max_bytes);
        int         total;
        logic [7:0] b;
        logic [7:0] xor_acc;
        xor_acc = '0;
        total = ((int'(bits) + 7) / 8) + 7;
        send_item(OP_START, 8'($urandom));
        for (int i = 0; i < total && i < max_bytes; i++)
        begin
            if ($urandom_range(99) < tick_pct)
            begin
                send_item(OP_TICK, 8'($urandom));
            end
            if (i == 0)
                b = HEADER_BYTE;
            else if (i == 1)
                b = {KIND_DATA, 5'($urandom)};
            else if (i == 2)
                b = bits[7:0];
            else if (i == 3)
                b = bits[15:8];
            else if (i == total - 1)
                b = corrupt ? (xor_acc ^ 8'($urandom_range(1, 255))) : xor_acc;
            else
                b = 8'($urandom);
            if (i >= 1 && i <= total - 2)
            begin
                xor_acc = xor_acc ^ b;
            end
            send_item(OP_BYTE, b);
        end
    endtask

    task automatic send_status_frame(input logic [7:0] code, input int extra_items);
        send_item(OP_START, 8'($urandom));
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_BYTE, code);
        for (int i = 0; i < extra_items; i++)
        begin
            send_item($urandom_range(1) ? OP_TICK : OP_BYTE, 8'($urandom));
        end
    endtask

    function automatic logic [7:0] unknown_status_code();
        logic [7:0] c;
        do
        begin
            c = {KIND_STATUS, 5'($urandom)};
        end
        while (c == ACK_BYTE || (c >= ERR_FIRST && c <= ERR_LAST) || c == ERR_NINE);
        return c;
    endfunction

    task automatic send_random_frame();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            send_data_frame(16'($urandom_range(0, 200)), $urandom_range(99) < 25, 4, 300);
        end
        else if (pick < 45)
        begin
            send_data_frame(16'($urandom), $urandom_range(1), 10, $urandom_range(2, 40));
        end
        else if (pick < 57)
        begin
            case ($urandom_range(3))
                0: b = ACK_BYTE;
                1: b = ERR_NINE;
                2: b = ERR_FIRST + 8'($urandom_range(0, 7));
                default: b = unknown_status_code();
            endcase
            send_status_frame(b, $urandom_range(0, 20));
        end
        else if (pick < 66)
        begin
            send_item(OP_START, 8'($urandom));
            send_item(OP_BYTE, 8'($urandom));
        end
        else if (pick < 75)
        begin
            send_item(OP_START, 8'($urandom));
            send_item(OP_BYTE, HEADER_BYTE);
            do
            begin
                b = 8'($urandom);
            end
            while (b[7:5] == KIND_DATA || b[7:5] == KIND_STATUS);
            send_item(OP_BYTE, b);
        end
        else if (pick < 85)
        begin
            send_item(OP_START, 8'($urandom));
            repeat ($urandom_range(1, 30))
            begin
                send_item($urandom_range(3) != 0 ? OP_TICK : OP_BYTE, 8'($urandom));
            end
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_item(2'($urandom_range(1, 3)), 8'($urandom));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 10))
            begin
                send_item(2'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_status_frames();
        send_status_frame(ACK_BYTE, 0);
        send_status_frame(ERR_FIRST, 0);
        send_status_frame(ERR_LAST, 0);
        send_status_frame(ERR_NINE, 0);
    endtask

    task automatic test_data_frames();
        send_data_frame(16'd0, 1'b0, 0, 300);
        send_data_frame(16'd9, 1'b1, 0, 300);
    endtask

    task automatic test_header_and_kind();
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_BYTE, 8'hE0);
    endtask

    task automatic test_ignored_and_restart();
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_START, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_BYTE, ACK_BYTE);
    endtask

    task automatic test_timeouts();
        write_timeout(8'd1);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        write_timeout(8'd0);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, HEADER_BYTE);
        send_item(OP_TICK, 8'h00);
        write_timeout(8'd3);
        send_data_frame(16'd100, 1'b0, 0, 6);
        repeat (3) send_item(OP_TICK, 8'h00);
        write_timeout(8'd255);
        send_status_frame(unknown_status_code(), 4);
        send_item(OP_START, 8'h00);
    endtask

    task automatic test_buffer_full();
        send_data_frame(16'd1985, 1'b0, 0, 300);
        send_data_frame(16'hFFFF, 1'b0, 0, BUFFER_BYTES_DEFAULT);
        send_status_frame(unknown_status_code(), 0);
        repeat (BUFFER_BYTES_DEFAULT - 2) send_item(OP_BYTE, 8'($urandom));
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req = 150;
        repeat (20)
        begin
            send_item(OP_START, 8'($urandom));
            send_item(OP_BYTE, 8'h00);
        end
        wait_drained();
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int stop_at;
        write_timeout(8'($urandom_range(6, 40)));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            send_random_frame();
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: verdict %0d bytes %0d",
                                          m_tdata[3:0], m_tdata[17:4]));
            end
            else
            begin
                oldest = verdict_q.pop_front();
                results_checked++;
                verdicts_seen[m_tdata[3:0]] = 1'b1;
                if (m_tdata[3:0] != oldest.verdict)
                begin
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              m_tdata[3:0], oldest.verdict));
                end
                if (m_tdata[17:4] != oldest.frame_bytes)
                begin
                    report_mismatch($sformatf("frame_bytes %0d, expected %0d",
                                              m_tdata[17:4], oldest.frame_bytes));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        pred_timeout = TIMEOUT_RESET;
        pred_stage = ST_IDLE;
        pred_count = '0;
        pred_len_low = '0;
        pred_frame_len = '0;
        pred_xor = '0;
        pred_ticks = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 75;
        test_status_frames();
        test_data_frames();
        test_header_and_kind();
        test_ignored_and_restart();
        test_timeouts();
        test_buffer_full();
        test_backpressure();

        run_random_phase(23, 75, 22);
        run_random_phase(75, 23, 22);
        run_random_phase(0, 0, 22);

        $display("Sent %0d frame transactions; %0d verdicts checked.", items_sent,
                 results_checked);
        $display("Verdict codes observed (bit per code): %b", verdicts_seen[14:0]);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
